/* hw/rtl/sce_pkg.sv */
package sce_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned CNT_W           = $clog2(DATA_W);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_OUT  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_HALT = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_VALUE     = 3'd1,
    ST_HALTED    = 3'd2,
    ST_SYNTAX    = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_DIVZERO   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

/* hw/rtl/sce_ram.sv */
module sce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sce_alu.sv */
// Iterative integer unit built around one 33-bit adder/subtractor.
// add/sub: no loop, mul: 32 shift-add steps, div: 2 abs + 32 restoring + 1 sign.
module sce_alu import sce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alu_req_t          req_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output alu_rsp_t          rsp_o
);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_ABSA = 6'b000010,
    A_ABSB = 6'b000100,
    A_MUL  = 6'b001000,
    A_DIV  = 6'b010000,
    A_NEG  = 6'b100000
  } alu_state_e;

  alu_state_e        state_q, state_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic [DATA_W-1:0] y_q, y_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic [DATA_W-1:0] res_q, res_d;

  logic [DATA_W-1:0] add_a, add_b, rem_sh;
  logic              add_sub;
  logic [DATA_W:0]   sum;
  logic              last;

  assign rem_sh = {acc_q[DATA_W-2:0], x_q[DATA_W-1]};
  assign last   = (cnt_q == CNT_W'(DATA_W - 1));

  // the single shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        add_a   = a_i;
        add_b   = b_i;
        add_sub = (req_i.op == ALU_SUB);
      end
      A_ABSA: begin
        add_b   = x_q;
        add_sub = 1'b1;
      end
      A_ABSB: begin
        add_b   = y_q;
        add_sub = 1'b1;
      end
      A_MUL: begin
        add_a = acc_q;
        add_b = x_q;
      end
      A_DIV: begin
        add_a   = rem_sh;
        add_b   = y_q;
        add_sub = 1'b1;
      end
      A_NEG: begin
        add_b   = x_q;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b ^ {DATA_W{add_sub}}}
             + {{DATA_W{1'b0}}, add_sub};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          acc_d = '0;
          x_d   = a_i;
          y_d   = b_i;
          cnt_d = '0;
          neg_d = a_i[DATA_W-1] ^ b_i[DATA_W-1];
          unique case (req_i.op)
            ALU_ADD, ALU_SUB: begin
              res_d  = sum[DATA_W-1:0];
              done_d = 1'b1;
            end
            ALU_MUL: state_d = A_MUL;
            ALU_DIV: state_d = A_ABSA;
            default: ;
          endcase
        end
      end
      A_ABSA: begin
        if (x_q[DATA_W-1]) begin
          x_d = sum[DATA_W-1:0];
        end
        state_d = A_ABSB;
      end
      A_ABSB: begin
        if (y_q[DATA_W-1]) begin
          y_d = sum[DATA_W-1:0];
        end
        state_d = A_DIV;
      end
      A_MUL: begin
        if (y_q[0]) begin
          acc_d = sum[DATA_W-1:0];
        end
        x_d   = {x_q[DATA_W-2:0], 1'b0};
        y_d   = {1'b0, y_q[DATA_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          res_d   = acc_d;
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_DIV: begin
        // carry out of rem - divisor means no borrow: quotient bit is one
        acc_d = sum[DATA_W] ? sum[DATA_W-1:0] : rem_sh;
        x_d   = {x_q[DATA_W-2:0], sum[DATA_W]};
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          state_d = A_NEG;
        end
      end
      A_NEG: begin
        res_d   = neg_q ? sum[DATA_W-1:0] : x_q;
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

/* hw/rtl/stack_calculator_engine.sv */
// Stack-machine calculator core.
// Input channel (in_valid_i/in_ready_o) carries one instruction word: operation_i
// and push_value_i. Output channel (out_valid_o/out_ready_i) returns exactly one
// word per instruction: status_o and out_value_o (popped value for out, else 0).
// One instruction is in flight at a time; in_ready_o is high only while the
// sequencer is idle. Push, halt, errors and words taken while halted go straight
// to the response state (S_RESP); out first pops the top in S_POP; add, sub, mul
// and div read the top (S_RD_TOP) and the second entry (S_RD_SEC), run in sce_alu
// (S_EXEC) and then respond; a divide by zero skips S_EXEC.
// The two stack reads go through the one read port of the stack RAM, and mul/div
// iterate one bit per cycle on the shared adder in sce_alu.
// The result sits in an output register, so the next word is taken while it waits;
// if the receiver still stalls when the next result is done, the sequencer holds.
// Reset empties the stack, clears the halt flag and drops out_valid_o; stack RAM
// contents are not cleared, entries above the depth are never read.
module stack_calculator_engine import sce_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               operation_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic signed [DATA_W-1:0] out_value_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD_TOP = 6'b000010,
    S_RD_SEC = 6'b000100,
    S_EXEC   = 6'b001000,
    S_POP    = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic              halted_q, halted_d;
  op_e               op_q, op_d;
  logic [DATA_W-1:0] top_q, top_d;
  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_value_q, res_value_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;

  logic              in_fire;
  op_e               op_in;
  logic [DW-1:0]     depth_m1, depth_m2;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  alu_op_e           alu_op;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign op_in      = op_e'(operation_i);
  assign depth_m1   = depth_q - DW'(1);
  assign depth_m2   = depth_q - DW'(2);

  always_comb begin
    unique case (op_q)
      OP_SUB:  alu_op = ALU_SUB;
      OP_MUL:  alu_op = ALU_MUL;
      OP_DIV:  alu_op = ALU_DIV;
      default: alu_op = ALU_ADD;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    halted_d     = halted_q;
    op_d         = op_q;
    top_d        = top_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    ram_we       = 1'b0;
    ram_waddr    = depth_q[AW-1:0];
    ram_wdata    = push_value_i;
    ram_raddr    = depth_m1[AW-1:0];
    alu_req      = '{start: 1'b0, op: alu_op};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d         = op_in;
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_RESP;
          if (halted_q) begin
            res_status_d = ST_HALTED;
          end else begin
            unique case (op_in)
              OP_PUSH: begin
                if (depth_q == DW'(STACK_DEPTH)) begin
                  res_status_d = ST_OVERFLOW;
                end else begin
                  ram_we  = 1'b1;
                  depth_d = depth_q + DW'(1);
                end
              end
              OP_OUT: begin
                if (depth_q == '0) begin
                  res_status_d = ST_UNDERFLOW;
                end else begin
                  state_d = S_POP;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (depth_q < DW'(2)) begin
                  res_status_d = ST_UNDERFLOW;
                end else begin
                  state_d = S_RD_TOP;
                end
              end
              OP_HALT: begin
                halted_d     = 1'b1;
                res_status_d = ST_HALTED;
              end
              default: res_status_d = ST_SYNTAX;
            endcase
          end
        end
      end
      S_POP: begin
        res_value_d  = ram_rdata;
        res_status_d = ST_VALUE;
        depth_d      = depth_m1;
        state_d      = S_RESP;
      end
      S_RD_TOP: begin
        top_d     = ram_rdata;
        ram_raddr = depth_m2[AW-1:0];
        state_d   = S_RD_SEC;
      end
      S_RD_SEC: begin
        if (op_q == OP_DIV && top_q == '0) begin
          res_status_d = ST_DIVZERO;
          state_d      = S_RESP;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_waddr = depth_m2[AW-1:0];
          ram_wdata = alu_rsp.result;
          depth_d   = depth_m1;
          state_d   = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    top_q        <= top_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  sce_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sce_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (ram_rdata),
    .b_i   (top_q),
    .rsp_o (alu_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_value_o = out_value_q;

endmodule

/* hw/rtl/sce_checker.sv */
module sce_checker import sce_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [2:0]               status_o,
  input logic signed [DATA_W-1:0] out_value_o
);

  logic halted_seen_q;

  // once a halted status has gone out, the block stays halted until reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && status_o == ST_HALTED) begin
      halted_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(out_value_o))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken right after accept");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_VALUE || out_value_o == '0))
    else $error("nonzero value without value-out status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_DIVZERO)
    else $error("status code out of range");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_seen_q |-> status_o == ST_HALTED)
    else $error("word after halt not reported as halted");

endmodule

bind stack_calculator_engine sce_checker u_sce_checker (.*);
